// File: design/ffa_pkg.sv
// Package for the first-fit block allocator: opcodes, status codes and field widths.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none
package ffa_pkg;
	localparam int OPCODE_W = 2;
	localparam int POOL_ID_W = 2;
	localparam int DATA_W = 32;
	localparam int SLACK_W = 12;
	localparam int STATUS_W = 2;
	localparam int CFG_INDEX_W = 1;

	localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_INIT  = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_STATS = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_POOL_BYTES  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SPLIT_SLACK = 1'd1;

	localparam int ALIGN_ADD = 255;

	typedef struct packed {
		logic [OPCODE_W-1:0]  opcode;
		logic [POOL_ID_W-1:0] pool_id;
		logic [DATA_W-1:0]    req_size;
		logic [DATA_W-1:0]    block_addr;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   alloc_addr;
		logic [DATA_W-1:0]   total_bytes;
		logic [DATA_W-1:0]   used_bytes;
		logic [DATA_W-1:0]   free_bytes;
	} rsp_t;

	typedef struct packed {
		logic [CFG_INDEX_W-1:0] index;
		logic [DATA_W-1:0]      data;
	} cfg_t;
endpackage
`default_nettype wire

// File: design/ffa_if.sv
// Valid/ready channel interface carrying one packed payload.
// Used for the request, response and configuration channels; depends on ffa_pkg.
`default_nettype none
interface ffa_req_if;
	logic valid;
	logic ready;
	ffa_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ffa_rsp_if;
	logic valid;
	logic ready;
	ffa_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ffa_cfg_if;
	logic valid;
	logic ready;
	ffa_pkg::cfg_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: design/first_fit_block_allocator.sv
// First-fit block allocator. Each pool's block table (offset, size, free mark) sits in one
// synchronous memory with a registered read; a sequencer walks it one entry per
// cycle. A pool holds at most MAX_ENTRIES entries. An alloc searches the table, then
// shifts entries up for a split. A free searches, then, if it found its block, runs one
// compaction pass that merges free runs. Requests are processed one at a time. A
// finished response waits in the output register while the next request is already
// taken, and a second response stalls until the first has been transferred.
// No clearing pass after reset is needed. Depends on ffa_pkg and ffa_if.
`default_nettype none
module first_fit_block_allocator #(
	parameter int POOLS = 4,
	parameter int MAX_ENTRIES = 64,
	parameter int ADDR_BITS = 32
) (
	input  wire clk,
	input  wire arst_n,
	ffa_cfg_if.sink cfg,
	ffa_req_if.sink req,
	ffa_rsp_if.source rsp
);
	localparam int PW = (POOLS > 1) ? $clog2(POOLS) : 1;
	localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int MW = PW + EW;
	localparam int AW = ADDR_BITS;
	localparam int DW = ffa_pkg::DATA_W;
	localparam int EXW = (AW > DW) ? AW : DW;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SRCH   = 4'd1;
	localparam logic [3:0] S_SHIFT  = 4'd2;
	localparam logic [3:0] S_SPLIT  = 4'd3;
	localparam logic [3:0] S_CMP    = 4'd4;
	localparam logic [3:0] S_CMPEND = 4'd5;
	localparam logic [3:0] S_RESP   = 4'd6;
	localparam logic [3:0] S_SRCHW  = 4'd7;
	localparam logic [3:0] S_SHIFTW = 4'd8;

	typedef struct packed {
		logic [AW-1:0] off;
		logic [AW-1:0] size;
		logic          free;
	} ent_t;

	// Block table memory, one row per pool and entry.
	ent_t mem [POOLS*MAX_ENTRIES];
	logic          mem_we;
	logic [MW-1:0] mem_waddr;
	ent_t          mem_wdata;
	logic [MW-1:0] mem_raddr;
	ent_t          rd_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[mem_raddr];
	end

	logic [DW-1:0]      pool_bytes_q;
	logic [ffa_pkg::SLACK_W-1:0] slack_q;
	logic [CW-1:0]      count_q [POOLS];
	logic [AW-1:0]      used_q  [POOLS];
	logic [AW-1:0]      total_q [POOLS];
	logic [POOLS-1:0]   ready_q;

	logic [3:0]    state_q;
	ffa_pkg::req_t r_q;
	logic [PW-1:0] p_q;
	logic [AW-1:0] aligned_q;
	logic [CW-1:0] idx_q;   // entry being read
	logic [CW-1:0] hit_q;   // found entry
	logic [CW-1:0] wr_q;    // compaction write pointer
	ent_t          acc_q;   // compaction accumulator
	ent_t          hold_q;  // entry found by alloc
	logic          rsp_valid_q;
	ffa_pkg::rsp_t rsp_q;
	logic [ffa_pkg::STATUS_W-1:0] st_q;
	logic [AW-1:0] addr_q;
	logic          rsp_load;

	assign cfg.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;
	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || rsp.ready);

	function automatic logic [MW-1:0] row(input logic [PW-1:0] p, input logic [CW-1:0] i);
		row = MW'(p) * MW'(MAX_ENTRIES) + MW'(i[EW-1:0]);
	endfunction

	logic [PW-1:0] in_p;
	logic          in_valid_pool;
	logic [EXW:0]  in_sum;
	logic [AW-1:0] in_aligned;
	logic          in_align_ovf;
	always_comb begin
		in_p = PW'(req.payload.pool_id);
		in_valid_pool = 32'(req.payload.pool_id) < POOLS;
		in_sum = (EXW+1)'(req.payload.req_size) + (EXW+1)'(ffa_pkg::ALIGN_ADD);
		in_align_ovf = |(in_sum >> AW);
		in_aligned = in_sum[AW-1:0] & ~AW'(ffa_pkg::ALIGN_ADD);
	end

	logic [CW-1:0] cnt;
	assign cnt = count_q[p_q];
	logic [AW-1:0] rem;
	assign rem = rd_q.size - aligned_q;
	logic fits;
	assign fits = rd_q.free && (rd_q.size >= aligned_q);

	// The entry being freed is seen as free during the compaction pass.
	ent_t cmp_cur;
	logic cmp_merge;
	always_comb begin
		cmp_cur = rd_q;
		if (idx_q == hit_q) cmp_cur.free = 1'b1;
		cmp_merge = acc_q.free && cmp_cur.free && (acc_q.off + acc_q.size == cmp_cur.off);
	end

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = row(p_q, idx_q);
		mem_wdata = rd_q;
		mem_raddr = row(p_q, idx_q);
		if (state_q == S_IDLE) begin
			mem_raddr = row(in_p, '0);
			mem_waddr = row(in_p, '0);
			mem_wdata.off = '0;
			mem_wdata.size = (DW > AW && |(EXW'(pool_bytes_q) >> AW)) ? {AW{1'b1}}
				: AW'(pool_bytes_q);
			mem_wdata.free = 1'b1;
			mem_we = req.valid && req.ready && req.payload.opcode == ffa_pkg::OP_INIT
				&& in_valid_pool;
		end else if (state_q == S_SHIFTW) begin
			mem_raddr = row(p_q, idx_q - CW'(1));
		end else if (state_q == S_SHIFT) begin
			// idx_q-1 has been read; write it one place up.
			mem_raddr = row(p_q, idx_q - CW'(2));
			mem_waddr = row(p_q, idx_q);
			mem_we = 1'b1;
		end else if (state_q == S_SPLIT) begin
			mem_we = 1'b1;
			mem_waddr = row(p_q, hit_q + CW'(1));
			mem_wdata.off = hold_q.off + aligned_q;
			mem_wdata.size = hold_q.size - aligned_q;
			mem_wdata.free = 1'b1;
		end else if (state_q == S_SRCH || state_q == S_CMP) begin
			mem_raddr = row(p_q, idx_q + CW'(1));
		end
		if (state_q == S_CMP && idx_q != '0) begin
			// Flush accumulator when the new entry does not merge.
			if (!cmp_merge) begin
				mem_we = 1'b1;
				mem_waddr = row(p_q, wr_q);
				mem_wdata = acc_q;
			end
		end else if (state_q == S_CMPEND) begin
			mem_we = 1'b1;
			mem_waddr = row(p_q, wr_q);
			mem_wdata = acc_q;
		end else if (state_q == S_RESP && hit_q != {CW{1'b1}} && r_q.opcode ==
			ffa_pkg::OP_ALLOC) begin
			mem_we = 1'b1;
			mem_waddr = row(p_q, hit_q);
			mem_wdata = hold_q;
			mem_wdata.free = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
			pool_bytes_q <= DW'(16777216);
			slack_q <= ffa_pkg::SLACK_W'(40);
			ready_q <= '0;
			for (int i = 0; i < POOLS; i++) begin
				count_q[i] <= '0;
				used_q[i] <= '0;
				total_q[i] <= '0;
			end
		end else begin
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.payload.index)
					ffa_pkg::REG_POOL_BYTES:  pool_bytes_q <= cfg.payload.data;
					ffa_pkg::REG_SPLIT_SLACK: slack_q <= cfg.payload.data[ffa_pkg::SLACK_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (req.valid && req.ready) begin
					r_q <= req.payload;
					p_q <= in_p;
					aligned_q <= in_aligned;
					idx_q <= '0;
					hit_q <= {CW{1'b1}};
					addr_q <= '0;
					st_q <= ffa_pkg::ST_OK;
					state_q <= S_RESP;
					if (req.payload.opcode == ffa_pkg::OP_INIT) begin
						if (in_valid_pool) begin
							total_q[in_p] <= mem_wdata.size;
							used_q[in_p] <= '0;
							ready_q[in_p] <= 1'b1;
							count_q[in_p] <= CW'(1);
						end else st_q <= ffa_pkg::ST_NOT_READY;
					end else if (!in_valid_pool || !ready_q[in_p]) begin
						st_q <= ffa_pkg::ST_NOT_READY;
					end else if (req.payload.opcode == ffa_pkg::OP_ALLOC) begin
						if (in_align_ovf) st_q <= ffa_pkg::ST_NO_FIT;
						else state_q <= S_SRCHW;
					end else if (req.payload.opcode == ffa_pkg::OP_FREE) begin
						state_q <= S_SRCHW;
					end
				end
				// A free that found its block comes back here as a stats request and
				// then runs the compaction pass.
				S_SRCHW: begin
					if (cnt == '0) state_q <= S_RESP;
					else if (r_q.opcode == ffa_pkg::OP_STATS) state_q <= S_CMP;
					else state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (cnt == '0 || idx_q >= cnt) begin
						st_q <= (r_q.opcode == ffa_pkg::OP_ALLOC) ? ffa_pkg::ST_NO_FIT
							: ffa_pkg::ST_NOT_FOUND;
						state_q <= S_RESP;
					end else if (r_q.opcode == ffa_pkg::OP_ALLOC && fits) begin
						hit_q <= idx_q;
						hold_q <= rd_q;
						addr_q <= rd_q.off;
						if (rem > AW'(slack_q) && cnt < CW'(MAX_ENTRIES)) begin
							used_q[p_q] <= used_q[p_q] + aligned_q;
							count_q[p_q] <= cnt + CW'(1);
							if (cnt > idx_q + CW'(1)) begin
								idx_q <= cnt;
								state_q <= S_SHIFTW;
							end else state_q <= S_SPLIT;
						end else begin
							used_q[p_q] <= used_q[p_q] + rd_q.size;
							state_q <= S_RESP;
						end
					end else if (r_q.opcode == ffa_pkg::OP_FREE && !rd_q.free
						&& rd_q.off == AW'(r_q.block_addr)
						&& (DW <= AW || (EXW'(r_q.block_addr) >> AW) == '0)) begin
						// Mark free in the accumulator and compact the whole table.
						used_q[p_q] <= used_q[p_q] - rd_q.size;
						hit_q <= idx_q;
						idx_q <= '0;
						wr_q <= '0;
						state_q <= S_SRCHW;
						r_q.opcode <= ffa_pkg::OP_STATS;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_SHIFTW: state_q <= S_SHIFT;
				S_SHIFT: begin
					idx_q <= idx_q - CW'(1);
					if (idx_q - CW'(1) == hit_q + CW'(1)) state_q <= S_SPLIT;
				end
				S_SPLIT: begin
					hold_q.size <= aligned_q;
					state_q <= S_RESP;
				end
				S_CMP: begin
					if (idx_q == '0) acc_q <= cmp_cur;
					else if (cmp_merge)
						acc_q.size <= acc_q.size + cmp_cur.size;
					else begin
						acc_q <= cmp_cur;
						wr_q <= wr_q + CW'(1);
					end
					idx_q <= idx_q + CW'(1);
					if (idx_q + CW'(1) >= cnt) state_q <= S_CMPEND;
				end
				S_CMPEND: begin
					count_q[p_q] <= wr_q + CW'(1);
					hit_q <= {CW{1'b1}};
					state_q <= S_RESP;
				end
				S_RESP: if (rsp_load) begin
					rsp_q.status <= st_q;
					rsp_q.alloc_addr <= (st_q == ffa_pkg::ST_OK && r_q.opcode == ffa_pkg::OP_ALLOC)
						? DW'(addr_q) : '0;
					if (st_q != ffa_pkg::ST_NOT_READY) begin
						rsp_q.total_bytes <= DW'(total_q[p_q]);
						rsp_q.used_bytes <= DW'(used_q[p_q]);
						rsp_q.free_bytes <= DW'(total_q[p_q] - used_q[p_q]);
					end else begin
						rsp_q.total_bytes <= '0;
						rsp_q.used_bytes <= '0;
						rsp_q.free_bytes <= '0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ap_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |=> rsp_valid_q && $stable(rsp_q))
		else $error("response changed while stalled");
	ap_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> count_q[p_q] <= CW'(MAX_ENTRIES))
		else $error("entry count beyond table depth");
	ap_resp_from: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_RESP) else $error("response out of sequence");
endmodule
`default_nettype wire

// File: tb/sv/ffa_tb_pkg.sv
// Scoreboard for the first-fit block allocator testbench: a predictor of the pool tables
// and a queue of expected responses. Depends on ffa_pkg.
package ffa_tb_pkg;
	import ffa_pkg::*;

	localparam int NPOOLS = 4;
	localparam int NENTRIES = 64;

	class alloc_scoreboard;
		logic [31:0] blk_off [NPOOLS][NENTRIES];
		logic [31:0] blk_size [NPOOLS][NENTRIES];
		bit blk_free [NPOOLS][NENTRIES];
		int unsigned blk_count [NPOOLS];
		logic [31:0] used [NPOOLS];
		logic [31:0] total [NPOOLS];
		bit ready [NPOOLS];
		logic [31:0] pool_bytes;
		logic [11:0] split_slack;
		rsp_t pending_rsp [$];
		int errors;

		function new();
			pool_bytes = 32'd16777216;
			split_slack = 12'd40;
			errors = 0;
			for (int p = 0; p < NPOOLS; p++) begin
				blk_count[p] = 0;
				used[p] = '0;
				total[p] = '0;
				ready[p] = 0;
			end
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
			if (idx == REG_POOL_BYTES)
				pool_bytes = val;
			else
				split_slack = val[11:0];
		endfunction

		function void drop_entry(int p, int i);
			for (int k = i; k + 1 < blk_count[p]; k++) begin
				blk_off[p][k] = blk_off[p][k+1];
				blk_size[p][k] = blk_size[p][k+1];
				blk_free[p][k] = blk_free[p][k+1];
			end
			blk_count[p]--;
		endfunction

		function void merge_free(int p);
			int i;
			i = 0;
			while (i + 1 < blk_count[p]) begin
				if (blk_free[p][i] && blk_free[p][i+1] &&
						blk_off[p][i] + blk_size[p][i] == blk_off[p][i+1]) begin
					blk_size[p][i] = blk_size[p][i] + blk_size[p][i+1];
					drop_entry(p, i + 1);
				end else begin
					i++;
				end
			end
		endfunction

		function logic [STATUS_W-1:0] take_block(int p, logic [31:0] want,
				output logic [31:0] addr);
			logic [32:0] aligned;
			aligned = ({1'b0, want} + 33'd255) & ~33'd255;
			addr = '0;
			if (aligned[32])
				return ST_NO_FIT;
			for (int i = 0; i < blk_count[p]; i++) begin
				if (!blk_free[p][i] || blk_size[p][i] < aligned[31:0])
					continue;
				if (blk_size[p][i] - aligned[31:0] > {20'd0, split_slack} &&
						blk_count[p] < NENTRIES) begin
					for (int k = blk_count[p]; k > i + 1; k--) begin
						blk_off[p][k] = blk_off[p][k-1];
						blk_size[p][k] = blk_size[p][k-1];
						blk_free[p][k] = blk_free[p][k-1];
					end
					blk_off[p][i+1] = blk_off[p][i] + aligned[31:0];
					blk_size[p][i+1] = blk_size[p][i] - aligned[31:0];
					blk_free[p][i+1] = 1;
					blk_size[p][i] = aligned[31:0];
					blk_count[p]++;
				end
				blk_free[p][i] = 0;
				used[p] = used[p] + blk_size[p][i];
				addr = blk_off[p][i];
				return ST_OK;
			end
			return ST_NO_FIT;
		endfunction

		function logic [STATUS_W-1:0] release_block(int p, logic [31:0] a);
			for (int i = 0; i < blk_count[p]; i++) begin
				if (blk_off[p][i] == a && !blk_free[p][i]) begin
					blk_free[p][i] = 1;
					used[p] = used[p] - blk_size[p][i];
					merge_free(p);
					return ST_OK;
				end
			end
			return ST_NOT_FOUND;
		endfunction

		// Notes an accepted request and queues the response it must produce.
		function void note_request(req_t r);
			rsp_t e;
			int p;
			logic [31:0] a;
			p = r.pool_id;
			e = '0;
			a = '0;
			if (r.opcode == OP_INIT) begin
				total[p] = pool_bytes;
				used[p] = '0;
				ready[p] = 1;
				blk_count[p] = 1;
				blk_off[p][0] = '0;
				blk_size[p][0] = pool_bytes;
				blk_free[p][0] = 1;
				e.status = ST_OK;
			end else if (!ready[p]) begin
				e.status = ST_NOT_READY;
			end else if (r.opcode == OP_ALLOC) begin
				e.status = take_block(p, r.req_size, a);
			end else if (r.opcode == OP_FREE) begin
				e.status = release_block(p, r.block_addr);
			end else begin
				e.status = ST_OK;
			end
			e.alloc_addr = (e.status == ST_OK) ? a : '0;
			if (ready[p]) begin
				e.total_bytes = total[p];
				e.used_bytes = used[p];
				e.free_bytes = total[p] - used[p];
			end
			pending_rsp.push_back(e);
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response %p", $time, got);
				errors++;
				return;
			end
			e = pending_rsp.pop_front();
			if (got.status !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
				errors++;
			end
			if (got.alloc_addr !== e.alloc_addr) begin
				$display("%0t: alloc_addr expected %h actual %h", $time, e.alloc_addr,
					got.alloc_addr);
				errors++;
			end
			if (got.total_bytes !== e.total_bytes) begin
				$display("%0t: total_bytes expected %h actual %h", $time, e.total_bytes,
					got.total_bytes);
				errors++;
			end
			if (got.used_bytes !== e.used_bytes) begin
				$display("%0t: used_bytes expected %h actual %h", $time, e.used_bytes,
					got.used_bytes);
				errors++;
			end
			if (got.free_bytes !== e.free_bytes) begin
				$display("%0t: free_bytes expected %h actual %h", $time, e.free_bytes,
					got.free_bytes);
				errors++;
			end
		endfunction
	endclass
endpackage

// File: tb/sv/first_fit_block_allocator_tb.sv
// Top of the first-fit block allocator testbench: clock, reset, request and config drivers,
// response sink. Depends on ffa_pkg, ffa_if and ffa_tb_pkg.
module first_fit_block_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ffa_pkg::*;
	import ffa_tb_pkg::*;

	localparam longint CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	ffa_cfg_if cfg ();
	ffa_req_if req ();
	ffa_rsp_if rsp ();

	first_fit_block_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg.sink),
		.req(req.sink),
		.rsp(rsp.source)
	);

	alloc_scoreboard sb;
	bit calm;
	longint cycles;
	logic [31:0] live_addr [NPOOLS][$];

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 32);
	endfunction

	// Response side: random stalls, checks each transfer.
	initial begin
		rsp.ready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready)
				sb.check_response(rsp.payload);
			@(negedge clk);
			rsp.ready = !idle_now();
		end
	end

	task automatic send_req(logic [1:0] op, logic [1:0] p, logic [31:0] sz,
			logic [31:0] a);
		req_t r;
		while (idle_now())
			@(negedge clk);
		r.opcode = op;
		r.pool_id = p;
		r.req_size = sz;
		r.block_addr = a;
		req.payload = r;
		req.valid = 1;
		do @(posedge clk); while (!req.ready);
		sb.note_request(r);
		@(negedge clk);
		req.valid = 0;
	endtask

	task automatic drain();
		while (sb.pending_rsp.size() != 0)
			@(negedge clk);
		repeat (600) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
		cfg_t c;
		c.index = idx;
		c.data = val;
		cfg.payload = c;
		cfg.valid = 1;
		do @(posedge clk); while (!cfg.ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg.valid = 0;
	endtask

	// Allocations are remembered per pool so that most frees hit a live block.
	task automatic do_alloc(logic [1:0] p, logic [31:0] sz);
		send_req(OP_ALLOC, p, sz, $urandom);
		if (sb.pending_rsp[sb.pending_rsp.size()-1].status == ST_OK)
			live_addr[p].push_back(sb.pending_rsp[sb.pending_rsp.size()-1].alloc_addr);
	endtask

	task automatic do_free(logic [1:0] p, bit hit);
		int k;
		logic [31:0] a;
		a = $urandom;
		if (hit && live_addr[p].size() != 0) begin
			k = $urandom_range(live_addr[p].size() - 1);
			a = live_addr[p][k];
			live_addr[p].delete(k);
		end
		send_req(OP_FREE, p, $urandom, a);
	endtask

	function automatic logic [31:0] rand_size();
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(255);
			2: return 32'hFFFFFFFF - $urandom_range(300);
			default: return $urandom_range(8192);
		endcase
	endfunction

	task automatic random_phase(int n);
		int pick;
		logic [1:0] p;
		for (int i = 0; i < n; i++) begin
			calm = (i % 400) > 300;
			p = $urandom_range(3);
			pick = $urandom_range(99);
			if (pick < 3) begin
				send_req(OP_INIT, p, $urandom, $urandom);
				live_addr[p].delete();
			end else if (pick < 50)
				do_alloc(p, rand_size());
			else if (pick < 88)
				do_free(p, $urandom_range(9) != 0);
			else if (pick < 93)
				do_free(p, 0);
			else
				send_req(OP_STATS, p, $urandom, $urandom);
			if (i == n / 2) begin
				// Hold off until every outstanding response has come back.
				while (sb.pending_rsp.size() != 0)
					@(negedge clk);
			end
		end
		calm = 0;
	endtask

	task automatic init_all();
		for (int p = 0; p < NPOOLS; p++) begin
			send_req(OP_INIT, p[1:0], '0, '0);
			live_addr[p].delete();
		end
	endtask

	initial begin
		sb = new();
		calm = 0;
		arst_n = 0;
		req.valid = 0;
		req.payload = '0;
		cfg.valid = 0;
		cfg.payload = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: requests to pools that are not ready yet, then init of pool 0 and edge-case allocs and frees on it.
		send_req(OP_ALLOC, 2'd0, 32'd100, '0);
		send_req(OP_FREE, 2'd1, '0, '0);
		send_req(OP_STATS, 2'd3, '0, '0);
		send_req(OP_INIT, 2'd0, '0, '0);
		send_req(OP_STATS, 2'd0, '0, '0);
		do_alloc(2'd0, 32'd0);
		do_alloc(2'd0, 32'd1);
		do_alloc(2'd0, 32'd256);
		do_alloc(2'd0, 32'hFFFFFFFF);
		do_alloc(2'd0, 32'hFFFFFF01);
		do_alloc(2'd0, 32'hFFFFFF00);
		do_alloc(2'd0, 32'd16777216);
		send_req(OP_FREE, 2'd0, '0, 32'h12345);
		send_req(OP_FREE, 2'd0, '0, 32'd0);
		send_req(OP_FREE, 2'd0, '0, 32'd0);
		send_req(OP_FREE, 2'd0, '0, 32'd256);
		send_req(OP_FREE, 2'd0, '0, 32'd512);
		live_addr[0].delete();
		drain();

		// Extreme pool size and no slack; pool 1 is filled until the table is full, then allocs go without split.
		write_reg(REG_POOL_BYTES, 32'hFFFFFFFF);
		write_reg(REG_SPLIT_SLACK, 32'd0);
		init_all();
		for (int i = 0; i < 70; i++)
			do_alloc(2'd1, 32'd200);
		do_alloc(2'd1, 32'd0);
		random_phase(450);
		drain();

		// Small pools with maximum slack: blocks with under 4096 bytes to spare handed out whole, frequent no-fit.
		write_reg(REG_POOL_BYTES, 32'd20000);
		write_reg(REG_SPLIT_SLACK, 32'd4095);
		init_all();
		random_phase(400);
		drain();

		write_reg(REG_POOL_BYTES, 32'd0);
		write_reg(REG_SPLIT_SLACK, 32'h00000FFF);
		init_all();
		do_alloc(2'd2, 32'd0);
		do_alloc(2'd2, 32'd1);
		drain();

		write_reg(REG_POOL_BYTES, 32'h00040000 | $urandom_range(255));
		write_reg(REG_SPLIT_SLACK, $urandom_range(4095));
		init_all();
		random_phase(450);
		drain();

		write_reg(REG_POOL_BYTES, 32'd16777216);
		write_reg(REG_SPLIT_SLACK, 32'd40);
		init_all();
		random_phase(400);
		drain();

		if (sb.errors == 0 && sb.pending_rsp.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// File: sim.f
design/ffa_pkg.sv
design/ffa_if.sv
design/first_fit_block_allocator.sv
tb/sv/ffa_tb_pkg.sv
tb/sv/first_fit_block_allocator_tb.sv
